### design/lte_pkg.sv
// ----------------------------------------------------------------------------
// LZ77 triplet encoder package
// Holds the default sizes, the queue depth and the engine state type.
// ----------------------------------------------------------------------------
package lte_pkg;

	localparam int WINDOW_SIZE_DEF     = 12;
	localparam int LOOKAHEAD_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH         = 2;

	typedef enum logic [1:0] {
		ST_TAKE,
		ST_SEARCH,
		ST_EMIT,
		ST_SHIFT
	} eng_state_t;

endpackage

### design/lte_fifo.sv
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out buffer with push/full and pop/empty.
// ----------------------------------------------------------------------------
module lte_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

### design/lte_engine.sv
// ----------------------------------------------------------------------------
// LZ77 match engine
// Holds window and lookahead, searches one offset per cycle, emits triplets.
// ----------------------------------------------------------------------------
module lte_engine #(
	parameter int WINDOW_SIZE     = 12,
	parameter int LOOKAHEAD_DEPTH = 16,
	parameter int OFF_W           = $clog2(WINDOW_SIZE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_empty,
	output logic             in_pop,
	input  logic [7:0]       in_byte,
	input  logic             in_eos,
	input  logic             out_full,
	output logic             out_push,
	output logic [OFF_W-1:0] out_offset,
	output logic [OFF_W-1:0] out_length,
	output logic [7:0]       out_literal,
	output logic             out_final
);
	import lte_pkg::*;

	localparam int OC_W = $clog2(WINDOW_SIZE + 2);
	localparam int LA_W = $clog2(LOOKAHEAD_DEPTH + 1);
	localparam int LI_W = $clog2(LOOKAHEAD_DEPTH);

	eng_state_t       state_q, state_d;
	logic [7:0]       win_q [WINDOW_SIZE];
	logic [7:0]       la_q  [LOOKAHEAD_DEPTH];
	logic [OFF_W-1:0] wf_q;
	logic [LA_W-1:0]  la_fill_q;
	logic [OC_W-1:0]  off_q;
	logic [OFF_W-1:0] best_len_q, best_off_q;
	logic [LA_W-1:0]  rem_q;
	logic             eos_q;
	logic [OFF_W-1:0] len_c;
	logic             search_done;
	logic             last_c;

	// Match length at the current offset: leading run of equal bytes.
	always_comb begin
		logic            run;
		logic            ok;
		logic [OC_W:0]   idx;
		run   = 1'b1;
		len_c = '0;
		for (int j = 0; j < LOOKAHEAD_DEPTH - 1; j++) begin
			idx = (OC_W + 1)'(wf_q) - (OC_W + 1)'(off_q) + (OC_W + 1)'(j);
			ok  = (j < int'(off_q)) && (j < int'(la_fill_q) - 1)
				&& (int'(idx) < WINDOW_SIZE);
			run = run && ok && (win_q[idx[OFF_W-1:0]] == la_q[j]);
			len_c = len_c + OFF_W'(run);
		end
	end

	assign search_done = (off_q > OC_W'(wf_q));
	assign last_c      = eos_q && ((LA_W'(best_len_q) + 1'b1) == la_fill_q);

	assign in_pop      = (state_q == ST_TAKE);
	assign out_push    = (state_q == ST_EMIT) && !out_full;
	assign out_offset  = best_off_q;
	assign out_length  = best_len_q;
	assign out_literal = la_q[LI_W'(best_len_q)];
	assign out_final   = last_c;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_TAKE: begin
				if (!in_empty && (in_eos
					|| (la_fill_q + 1'b1) == LA_W'(LOOKAHEAD_DEPTH))) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (search_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_full) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (rem_q == LA_W'(1)) begin
					state_d = (eos_q && la_fill_q != LA_W'(1)) ? ST_SEARCH : ST_TAKE;
				end
			end
			default: state_d = ST_TAKE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_TAKE;
			wf_q      <= '0;
			la_fill_q <= '0;
			off_q     <= '0;
			rem_q     <= '0;
			eos_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_TAKE: begin
					if (!in_empty) begin
						la_fill_q <= la_fill_q + 1'b1;
						eos_q     <= in_eos;
						off_q     <= OC_W'(1);
					end
				end
				ST_SEARCH: begin
					if (!search_done) begin
						off_q <= off_q + 1'b1;
					end
				end
				ST_EMIT: begin
					rem_q <= LA_W'(best_len_q) + 1'b1;
				end
				ST_SHIFT: begin
					rem_q     <= rem_q - 1'b1;
					la_fill_q <= la_fill_q - 1'b1;
					off_q     <= OC_W'(1);
					if (rem_q == LA_W'(1) && eos_q && la_fill_q == LA_W'(1)) begin
						wf_q <= '0;
					end else if (wf_q != OFF_W'(WINDOW_SIZE)) begin
						wf_q <= wf_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Byte storage and best-match tracking carry no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_TAKE: begin
				if (!in_empty) begin
					la_q[LI_W'(la_fill_q)] <= in_byte;
				end
				best_len_q <= '0;
				best_off_q <= '0;
			end
			ST_SEARCH: begin
				if (!search_done && len_c > best_len_q) begin
					best_len_q <= len_c;
					best_off_q <= OFF_W'(off_q);
				end
			end
			ST_SHIFT: begin
				for (int i = 0; i < LOOKAHEAD_DEPTH - 1; i++) begin
					la_q[i] <= la_q[i+1];
				end
				if (wf_q == OFF_W'(WINDOW_SIZE)) begin
					for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
						win_q[i] <= win_q[i+1];
					end
					win_q[WINDOW_SIZE-1] <= la_q[0];
				end else begin
					win_q[wf_q] <= la_q[0];
				end
				best_len_q <= '0;
				best_off_q <= '0;
			end
			default: ;
		endcase
	end

endmodule

### design/lz77_triplet_encoder.sv
// ----------------------------------------------------------------------------
// LZ77 triplet encoder
// Sliding-window compressor emitting (offset, length, literal) triplets.
// ----------------------------------------------------------------------------
//  Channel  | Handshake          | Word
//  input    | push / full        | data_byte, end_of_stream
//  result   | empty / pop        | match_offset, match_length, next_literal,
//           |                    | final_triplet
//
// An input word is taken into a two-entry queue and then moved into the
// lookahead in the engine's take state. When the lookahead fills, or on the
// end mark, the engine compares one window start position per cycle, then
// emits a triplet and shifts length plus one bytes into the window at one
// byte per cycle. A full result queue stalls the engine and so the intake.
// Reset clears all fill counts and queue pointers; no clearing pass is run.
// ----------------------------------------------------------------------------
module lz77_triplet_encoder #(
	parameter int WINDOW_SIZE     = lte_pkg::WINDOW_SIZE_DEF,
	parameter int LOOKAHEAD_DEPTH = lte_pkg::LOOKAHEAD_DEPTH_DEF,
	parameter int OFF_W           = $clog2(WINDOW_SIZE + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       data_byte,
	input  logic             end_of_stream,
	output logic             empty,
	input  logic             pop,
	output logic [OFF_W-1:0] match_offset,
	output logic [OFF_W-1:0] match_length,
	output logic [7:0]       next_literal,
	output logic             final_triplet
);
	import lte_pkg::*;

	localparam int RES_W = 2 * OFF_W + 9;

	logic             in_empty, in_pop, in_eos;
	logic [7:0]       in_byte;
	logic             out_full, out_push, out_final;
	logic [OFF_W-1:0] out_offset, out_length;
	logic [7:0]       out_literal;

	// Front: input words wait here while the engine searches, up to two words.
	lte_fifo #(
		.WIDTH(9),
		.DEPTH(QUEUE_DEPTH)
	) u_in_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata ({end_of_stream, data_byte}),
		.pop   (in_pop),
		.empty (in_empty),
		.rdata ({in_eos, in_byte})
	);

	// Back: match search and window update.
	lte_engine #(
		.WINDOW_SIZE    (WINDOW_SIZE),
		.LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH),
		.OFF_W          (OFF_W)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_empty   (in_empty),
		.in_pop     (in_pop),
		.in_byte    (in_byte),
		.in_eos     (in_eos),
		.out_full   (out_full),
		.out_push   (out_push),
		.out_offset (out_offset),
		.out_length (out_length),
		.out_literal(out_literal),
		.out_final  (out_final)
	);

	// Results wait here; once the queue fills, a consumer stall stops the engine.
	lte_fifo #(
		.WIDTH(RES_W),
		.DEPTH(QUEUE_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.full  (out_full),
		.wdata ({out_final, out_literal, out_length, out_offset}),
		.pop   (pop),
		.empty (empty),
		.rdata ({final_triplet, next_literal, match_length, match_offset})
	);

endmodule
